@@ rtl/sasc_pkg.sv @@
// ----------------------------------------------------------------------------
// sasc_pkg
// Types and constants shared by the servo angle sweep controller modules.
// ----------------------------------------------------------------------------
package sasc_pkg;

  // Mode register codes. Code 3 has no meaning; it behaves like manual mode
  // for ticks and ignores encoder steps.
  typedef enum logic [1:0] {
    MODE_MANUAL = 2'd0,
    MODE_SCAN   = 2'd1,
    MODE_MIDDLE = 2'd2
  } mode_t;

  // Input transaction kinds.
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  // Digit select codes. Zero and three both select a weight of one.
  localparam logic [1:0] DIGIT_HUNDRED = 2'd1;
  localparam logic [1:0] DIGIT_TEN     = 2'd2;

  localparam logic [6:0] WEIGHT_ONE     = 7'd1;
  localparam logic [6:0] WEIGHT_TEN     = 7'd10;
  localparam logic [6:0] WEIGHT_HUNDRED = 7'd100;

  localparam logic [7:0]  MAX_ANGLE    = 8'd180;
  localparam logic [7:0]  MIDDLE_ANGLE = 8'd90;
  localparam logic [7:0]  ANGLE_TOP    = 8'd255;
  localparam logic [3:0]  MAX_SPEED    = 4'd8;
  localparam logic [15:0] TICK_PERIOD  = 16'd20;

  // One input transaction as held in the input register.
  typedef struct packed {
    logic       cmd;
    logic       turn_up;
    logic [1:0] digit_select;
  } item_t;

  // Architectural state of the controller.
  typedef struct packed {
    logic [7:0]  angle;
    logic [3:0]  speed;
    logic [15:0] tick_count;
    logic        direction;
  } state_t;

endpackage

@@ rtl/sasc_input_stage.sv @@
// ----------------------------------------------------------------------------
// sasc_input_stage
// Input register with valid/stall handshake in front of the update logic.
// ----------------------------------------------------------------------------
module sasc_input_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  sasc_pkg::item_t item_in,
  input  logic          take,
  output logic          held_valid,
  output sasc_pkg::item_t item_out
);
  import sasc_pkg::*;

  logic accept;

  // The register can load when it is empty or its transaction leaves now.
  assign in_stall = held_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_out <= item_in;
    end
  end

endmodule

@@ rtl/sasc_update.sv @@
// ----------------------------------------------------------------------------
// sasc_update
// Next-state logic: applies one tick or encoder step to the controller state.
// ----------------------------------------------------------------------------
module sasc_update (
  input  logic [1:0]       mode,
  input  sasc_pkg::item_t  item,
  input  sasc_pkg::state_t state,
  output sasc_pkg::state_t state_next
);
  import sasc_pkg::*;

  logic [6:0]  weight;
  logic [8:0]  man_up;
  logic [7:0]  man_down;
  logic [8:0]  man_sum;
  logic [7:0]  man_angle;
  logic [3:0]  spd_down;
  logic [3:0]  spd_new;
  logic [15:0] tick_inc;
  logic [16:0] scan_level;
  logic        scan_fire;
  logic        mid_fire;
  logic [7:0]  scan_angle;

  always_comb begin
    case (item.digit_select)
      DIGIT_HUNDRED: weight = WEIGHT_HUNDRED;
      DIGIT_TEN:     weight = WEIGHT_TEN;
      default:       weight = WEIGHT_ONE;
    endcase
  end

  // Manual step: add or subtract the weight, floor at zero, clamp to the top.
  assign man_up    = {1'b0, state.angle} + {2'b00, weight};
  assign man_down  = (state.angle < {1'b0, weight}) ? 8'd0 : state.angle - {1'b0, weight};
  assign man_sum   = item.turn_up ? man_up : {1'b0, man_down};
  assign man_angle = (man_sum > {1'b0, MAX_ANGLE}) ? MAX_ANGLE : man_sum[7:0];

  // Scan step: speed level moves by one within 0..MAX_SPEED.
  assign spd_down = (state.speed == 4'd0) ? 4'd0 : state.speed - 4'd1;
  always_comb begin
    if (item.turn_up) begin
      spd_new = (state.speed >= MAX_SPEED) ? MAX_SPEED : state.speed + 4'd1;
    end else begin
      spd_new = (spd_down > MAX_SPEED) ? MAX_SPEED : spd_down;
    end
  end

  // Scan threshold is 20 - 2*speed; compare count + 2*speed against 20 instead.
  assign tick_inc   = state.tick_count + 16'd1;
  assign scan_level = {1'b0, tick_inc} + {12'd0, state.speed, 1'b0};
  assign scan_fire  = scan_level >= {1'b0, TICK_PERIOD};
  assign mid_fire   = (tick_inc >= TICK_PERIOD) && (state.angle < MIDDLE_ANGLE);

  always_comb begin
    if (state.direction) begin
      scan_angle = (state.angle != 8'd0) ? state.angle - 8'd1 : state.angle;
    end else begin
      scan_angle = (state.angle != ANGLE_TOP) ? state.angle + 8'd1 : state.angle;
    end
  end

  always_comb begin
    state_next = state;
    if (item.cmd == CMD_STEP) begin
      case (mode)
        MODE_MANUAL: state_next.angle = man_angle;
        MODE_SCAN:   state_next.speed = spd_new;
        default:     state_next = state;
      endcase
    end else begin
      state_next.tick_count = tick_inc;
      case (mode)
        MODE_MIDDLE: begin
          state_next.direction = 1'b0;
          if (mid_fire) begin
            state_next.angle      = state.angle + 8'd1;
            state_next.tick_count = 16'd0;
          end
        end
        MODE_SCAN: begin
          if (scan_fire) begin
            state_next.angle      = scan_angle;
            state_next.tick_count = 16'd0;
            if (!state.direction && (scan_angle >= MAX_ANGLE)) begin
              state_next.direction = 1'b1;
            end else if (state.direction && (scan_angle == 8'd0)) begin
              state_next.direction = 1'b0;
            end
          end
        end
        default: state_next.tick_count = tick_inc;
      endcase
    end
  end

endmodule

@@ rtl/servo_angle_sweep_controller.sv @@
// ----------------------------------------------------------------------------
// servo_angle_sweep_controller
// Servo angle keeper driven by timer ticks and encoder detent steps.
// ----------------------------------------------------------------------------
// The controller takes one transaction per clock cycle, back to back, and
// returns exactly one result transaction for each input transaction, through
// the input register and then the state/result register. Each transaction is
// either a timer tick or an encoder step; the result carries the angle, scan
// speed and scan direction after that transaction. The rate is set by the
// single read-modify-write of the state registers, done combinationally
// between the input register and the state/result register. Throughput
// drops only while the output side stalls. The operating mode register is
// written through the cfg channel, which is always ready; write it only while
// no transaction is in flight. Mode 0 is manual setting (steps move the angle
// by 1, 10 or 100 within 0..180), mode 1 is back-and-forth scanning (steps
// change the speed level 0..8, ticks move the angle every 20 - 2*speed ticks)
// and mode 2 ramps the angle up to 90, one degree every 20 ticks.
// ----------------------------------------------------------------------------
module servo_angle_sweep_controller (
  input  logic       clk,
  input  logic       rst,
  // Configuration write channel.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data,
  // Input transaction channel.
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd,
  input  logic       turn_up,
  input  logic [1:0] digit_select,
  // Result transaction channel.
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] angle,
  output logic [3:0] speed,
  output logic       sweeping_down
);
  import sasc_pkg::*;

  logic [1:0] mode;
  item_t      item_in;
  item_t      item_held;
  logic       held_valid;
  logic       advance;
  state_t     state;
  state_t     state_next;

  // The mode register accepts a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_MANUAL;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  assign item_in.cmd          = cmd;
  assign item_in.turn_up      = turn_up;
  assign item_in.digit_select = digit_select;

  // A held transaction moves on when the result slot is empty or being
  // emptied in this cycle.
  assign advance = held_valid && (!out_valid || !out_stall);

  sasc_input_stage u_input (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .item_in    (item_in),
    .take       (advance),
    .held_valid (held_valid),
    .item_out   (item_held)
  );

  sasc_update u_update (
    .mode       (mode),
    .item       (item_held),
    .state      (state),
    .state_next (state_next)
  );

  // The state registers double as the result register: they change only
  // when a new result is loaded, so the outputs read them directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign angle         = state.angle;
  assign speed         = state.speed;
  assign sweeping_down = state.direction;

`ifndef SYNTHESIS
  // Results must not change unless a new transaction is loaded.
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(angle) && $stable(speed) && $stable(sweeping_down)))
    else $error("state changed without a transaction");

  // The speed level never leaves its range.
  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    speed <= MAX_SPEED)
    else $error("speed level above maximum");

  // A manual step always leaves the angle within the servo range.
  a_manual_clamp: assert property (@(posedge clk) disable iff (rst)
    (advance && (mode == MODE_MANUAL) && (item_held.cmd == CMD_STEP))
      |=> (angle <= MAX_ANGLE))
    else $error("manual step left angle out of range");

  // A tick in middle mode always sets the direction to up.
  a_middle_up: assert property (@(posedge clk) disable iff (rst)
    (advance && (mode == MODE_MIDDLE) && (item_held.cmd == CMD_TICK))
      |=> !sweeping_down)
    else $error("middle mode tick left direction down");
`endif

endmodule

@@ tb/sv/servo_angle_sweep_controller_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// servo_angle_sweep_controller_test
// Self-checking regression for the servo angle sweep controller.
// ----------------------------------------------------------------------------
// A behavioral model of the angle, speed, tick and direction registers runs
// next to the block and predicts the result of every accepted transaction.
// The run covers a short directed pass, a climb of the angle a few degrees
// past the maximum and random traffic in every mode, with random idling on
// both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module servo_angle_sweep_controller_test;
  import sasc_pkg::*;

  // The unnamed fourth mode code: ticks only count and steps do nothing.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int CYCLE_LIMIT   = 1000000;
  // Settling margin after the last result has come back.
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 120;
  localparam int SEGMENTS      = 9;
  // Scan moves taken above the maximum angle during the climb.
  localparam int CLIMB_STEPS   = 4;

  // One result transaction as seen on the output port.
  typedef struct {
    logic [7:0] angle;
    logic [3:0] speed;
    logic       down;
  } sweep_result_t;

  // Tracks the controller state and checks results in order.
  class sweep_scoreboard;
    logic [7:0]    angle_q;
    logic [3:0]    speed_q;
    logic [15:0]   ticks;
    logic          down_q;
    logic [1:0]    mode;
    sweep_result_t expected_q[$];
    int unsigned   failures;

    function new();
      angle_q  = '0;
      speed_q  = '0;
      ticks    = '0;
      down_q   = 1'b0;
      mode     = MODE_MANUAL;
      failures = 0;
    endfunction

    // Advances the model by one accepted input transaction.
    function void note_item(cmd_t kind, logic up, logic [1:0] digit);
      int            v;
      int            w;
      int            thr;
      sweep_result_t r;
      if (kind == CMD_STEP) begin
        case (mode)
          MODE_MANUAL: begin
            if (digit == DIGIT_HUNDRED) w = int'(WEIGHT_HUNDRED);
            else if (digit == DIGIT_TEN) w = int'(WEIGHT_TEN);
            else w = int'(WEIGHT_ONE);
            v = int'(angle_q) + (up ? w : -w);
            if (v > int'(MAX_ANGLE)) v = int'(MAX_ANGLE);
            if (v < 0) v = 0;
            angle_q = v[7:0];
          end
          MODE_SCAN: begin
            v = int'(speed_q) + (up ? 1 : -1);
            if (v > int'(MAX_SPEED)) v = int'(MAX_SPEED);
            if (v < 0) v = 0;
            speed_q = v[3:0];
          end
          default: ;
        endcase
      end else begin
        ticks = ticks + 16'd1;
        if (mode == MODE_MIDDLE) begin
          down_q = 1'b0;
          if (ticks >= TICK_PERIOD && angle_q < MIDDLE_ANGLE) begin
            angle_q = angle_q + 8'd1;
            ticks   = '0;
          end
        end else if (mode == MODE_SCAN) begin
          thr = int'(TICK_PERIOD) - 2 * int'(speed_q);
          if (int'(ticks) >= thr) begin
            if (!down_q) begin
              if (angle_q < ANGLE_TOP) angle_q = angle_q + 8'd1;
              if (angle_q >= MAX_ANGLE) down_q = 1'b1;
            end else begin
              if (angle_q > 8'd0) angle_q = angle_q - 8'd1;
              if (angle_q == 8'd0) down_q = 1'b0;
            end
            ticks = '0;
          end
        end
      end
      r.angle = angle_q;
      r.speed = speed_q;
      r.down  = down_q;
      expected_q.push_back(r);
    endfunction

    // Compares one accepted result transaction with the oldest prediction.
    function void check_result(logic [7:0] a, logic [3:0] s, logic d);
      sweep_result_t r;
      if (expected_q.size() == 0) begin
        $error("result transaction with no prediction pending");
        failures++;
        return;
      end
      r = expected_q.pop_front();
      if (a !== r.angle) begin
        $error("angle: expected %0d, got %0d", r.angle, a);
        failures++;
      end
      if (s !== r.speed) begin
        $error("speed: expected %0d, got %0d", r.speed, s);
        failures++;
      end
      if (d !== r.down) begin
        $error("sweeping_down: expected %0b, got %0b", r.down, d);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data     = '0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic       cmd          = 1'b0;
  logic       turn_up      = 1'b0;
  logic [1:0] digit_select = '0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [7:0] angle;
  logic [3:0] speed;
  logic       sweeping_down;

  sweep_scoreboard sb = new();

  // Idle percentages for the two channels, changed by the main sequence.
  int send_idle_pct = 8;
  int recv_idle_pct = 64;

  // The main sequence bumps hold_reqs to ask for a long output hold-off; the
  // output process alone owns the countdown.
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycles    = 0;

  // Random segment plan: mode and length of each stretch of traffic.
  logic [1:0] seg_mode [SEGMENTS] = '{MODE_MANUAL, MODE_SCAN, MODE_MIDDLE,
                                      MODE_SCAN, MODE_MANUAL, MODE_SPARE,
                                      MODE_SCAN, MODE_MIDDLE, MODE_MANUAL};
  int         seg_len  [SEGMENTS] = '{40, 90, 60, 90, 40, 20, 60, 20, 30};

  servo_angle_sweep_controller dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .turn_up      (turn_up),
    .digit_select (digit_select),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .angle        (angle),
    .speed        (speed),
    .sweeping_down(sweeping_down)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Output side. A result transaction is taken on the edge where out_valid
  // is high and our stall was low; both are read before this edge's updates.
  // The stall for the next cycle is then chosen, either from a pending long
  // hold-off or at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        sb.check_result(angle, speed, sweeping_down);
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offers one input transaction and returns on the edge that accepts it.
  // Valid is left high afterwards so that back-to-back transactions need no
  // second assignment in the same time step; the caller lowers it when the
  // stream pauses. The payload only changes once the previous one is taken.
  task automatic send_item(input cmd_t kind, input logic up, input logic [1:0] digit);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    cmd          <= kind;
    turn_up      <= up;
    digit_select <= digit;
    do @(posedge clk); while (in_stall);
    sb.note_item(kind, up, digit);
  endtask

  // Stops offering transactions and waits until every predicted result has
  // come back, then lets the pipeline settle.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mode changes only happen with nothing in flight.
  task automatic write_mode(input logic [1:0] m);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.mode = m;
  endtask

  initial begin
    cmd_t       kind;
    logic       up;
    logic [1:0] digit;
    int         step_pct;
    int         up_pct;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass. Manual mode first: every digit weight, the clamp at the
    // top of the range, the clamp at zero, and a tick that only counts.
    write_mode(MODE_MANUAL);
    send_item(CMD_STEP, 1'b1, DIGIT_HUNDRED);
    send_item(CMD_STEP, 1'b1, DIGIT_TEN);
    send_item(CMD_STEP, 1'b1, 2'd0);
    send_item(CMD_STEP, 1'b1, 2'd3);
    send_item(CMD_STEP, 1'b1, DIGIT_HUNDRED);
    send_item(CMD_STEP, 1'b0, DIGIT_HUNDRED);
    send_item(CMD_STEP, 1'b0, DIGIT_HUNDRED);
    send_item(CMD_TICK, 1'b1, 2'd3);

    // Scan mode: speed below zero, then up past its maximum.
    write_mode(MODE_SCAN);
    send_item(CMD_STEP, 1'b0, 2'd0);
    repeat (9) send_item(CMD_STEP, 1'b1, 2'd3);
    send_item(CMD_TICK, 1'b0, 2'd0);

    // The spare mode code and middle mode: steps change nothing.
    write_mode(MODE_SPARE);
    send_item(CMD_STEP, 1'b1, DIGIT_HUNDRED);
    send_item(CMD_TICK, 1'b1, 2'd0);
    write_mode(MODE_MIDDLE);
    send_item(CMD_STEP, 1'b1, DIGIT_TEN);
    send_item(CMD_TICK, 1'b0, 2'd0);

    // Climb. Set the angle to the maximum by hand, then scan up until the
    // direction flips, which leaves the angle one past the maximum. A single
    // middle-mode tick clears the direction, so each further scan move takes
    // the angle one more degree above the maximum.
    write_mode(MODE_MANUAL);
    send_item(CMD_STEP, 1'b1, DIGIT_HUNDRED);
    send_item(CMD_STEP, 1'b1, DIGIT_HUNDRED);
    write_mode(MODE_SCAN);
    while (!sb.down_q) send_item(CMD_TICK, 1'b0, 2'd0);
    repeat (CLIMB_STEPS) begin
      write_mode(MODE_MIDDLE);
      send_item(CMD_TICK, 1'b1, 2'd0);
      write_mode(MODE_SCAN);
      while (!sb.down_q) send_item(CMD_TICK, 1'b0, 2'd0);
    end

    // A manual step from above the maximum clamps to it. Bring the angle to
    // zero with the direction still down, so the next scan move holds the
    // angle at zero and turns the sweep back up.
    write_mode(MODE_MANUAL);
    send_item(CMD_STEP, 1'b1, 2'd0);
    send_item(CMD_STEP, 1'b0, DIGIT_HUNDRED);
    send_item(CMD_STEP, 1'b0, DIGIT_HUNDRED);
    write_mode(MODE_SCAN);
    while (sb.down_q) send_item(CMD_TICK, 1'b1, 2'd0);

    // Random traffic, one stretch per segment. The first three segments idle
    // mostly on the output side, the next three mostly on the input side and
    // the last three not at all. Scan stretches are mostly ticks with a bias
    // toward speeding up, so the angle actually travels.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      write_mode(seg_mode[seg]);
      if (seg < 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 64;
      end else if (seg < 6) begin
        send_idle_pct = 64;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg_mode[seg])
        MODE_MANUAL: begin step_pct = 75; up_pct = 50; end
        MODE_SCAN:   begin step_pct = 15; up_pct = 70; end
        MODE_MIDDLE: begin step_pct = 10; up_pct = 50; end
        default:     begin step_pct = 50; up_pct = 50; end
      endcase
      for (int n = 0; n < seg_len[seg]; n++) begin
        // Long output hold-off while the input keeps streaming, so the
        // block backs up and stalls its input.
        if (seg == 7 && n == 5) hold_reqs <= hold_reqs + 1;
        kind  = ($urandom_range(99) < step_pct) ? CMD_STEP : CMD_TICK;
        up    = ($urandom_range(99) < up_pct);
        digit = 2'($urandom_range(3));
        send_item(kind, up, digit);
      end
    end

    wait_for_results();
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
